// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the queue, front and back rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/lctwd_pkg.sv =====
// -----------------------------------------------------------------------------
// lctwd_pkg
// Types and constants of the load-cell tare, weigh and display block.
// -----------------------------------------------------------------------------
package lctwd_pkg;

   // weight and gain formats
   localparam int WEIGHT_BITS = 16;
   localparam int GAIN_BITS   = 16;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd16591;
   localparam logic [16:0] ROUND_Q16 = 17'd3277;

   // divide by 100 as multiply by ceil(2^37 / 100), exact for 32-bit samples
   localparam int MUL_BITS     = 31;
   localparam int DIV100_SHIFT = 37;
   localparam logic [MUL_BITS-1:0] DIV100_MUL = 31'h51EB851F;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // display bytes
   localparam logic [7:0] CURSOR_LINE2 = 8'hC0;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_UNIT    = 8'h67;

   // sequencer positions
   localparam logic [3:0] HEAD_LAST   = 4'd8;
   localparam logic [2:0] DIGIT_LAST  = 3'd4;
   localparam logic [3:0] CONV_CYCLES = 4'd8;
   localparam int BCD_BITS = 20;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_HEAD,
      SEQ_DIGIT,
      SEQ_SPACE,
      SEQ_UNIT
   } seq_state_type;

endpackage

// ===== rtl/lctwd_if.sv =====
// -----------------------------------------------------------------------------
// lctwd channel interfaces
// Request, display-byte and gain-register channels with valid/ready.
// -----------------------------------------------------------------------------
interface lctwd_req_if #(parameter int SAMPLE_BITS = 24);
   logic                   valid;
   logic                   ready;
   logic                   req_type;
   logic [SAMPLE_BITS-1:0] sample;
   modport source (output valid, req_type, sample, input ready);
   modport sink (input valid, req_type, sample, output ready);
endinterface

interface lctwd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] lcd_byte;
   logic       is_command;
   logic       last;
   modport source (output valid, lcd_byte, is_command, last, input ready);
   modport sink (input valid, lcd_byte, is_command, last, output ready);
endinterface

interface lctwd_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] gain_q16;
   modport source (output valid, gain_q16, input ready);
   modport sink (input valid, gain_q16, output ready);
endinterface

// ===== rtl/lctwd_fifo.sv =====
// -----------------------------------------------------------------------------
// lctwd_fifo
// Short register queue carrying weights from the front to the back.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module lctwd_fifo #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push;

   // status
   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push_valid & ~full;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_IMPLIES(a_fifo_count_bound, clock, reset, 1'b1, count_ff <= CNT_FULL)
   `ASSERT_IMPLIES(a_fifo_no_underflow, clock, reset, pop, count_ff != '0)

endmodule

// ===== rtl/lctwd_front.sv =====
// -----------------------------------------------------------------------------
// lctwd_front
// Accepts requests, divides by 100, keeps the tare and computes the weight.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module lctwd_front
   import lctwd_pkg::*;
#(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   lctwd_req_if.sink              req_ch,
   lctwd_csr_if.sink              csr_ch,
   output logic                   push_valid,
   output logic [WEIGHT_BITS-1:0] push_data,
   input  logic                   push_full
);

   localparam int LEVEL_BITS = SAMPLE_BITS - 6;
   localparam int PROD_BITS  = SAMPLE_BITS + MUL_BITS;
   localparam int NET_BITS   = LEVEL_BITS + GAIN_BITS;
   localparam int SUM_BITS   = (NET_BITS + 1 > 33) ? NET_BITS + 1 : 33;

   logic                   stall;
   logic                   advance;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_weigh_ff, s1_weigh_in;
   logic [SAMPLE_BITS-1:0] s1_sample_ff, s1_sample_in;

   logic                   s2_valid_ff, s2_valid_in;
   logic                   s2_weigh_ff, s2_weigh_in;
   logic [PROD_BITS-1:0]   s2_prod_ff, s2_prod_in;

   logic                   s3_valid_ff, s3_valid_in;
   logic                   s3_upd_ff, s3_upd_in;
   logic [NET_BITS-1:0]    s3_prod_ff, s3_prod_in;

   logic [LEVEL_BITS-1:0]  tare_ff, tare_in;
   logic [WEIGHT_BITS-1:0] net_weight_ff, net_weight_in;
   logic [GAIN_BITS-1:0]   gain_ff, gain_in;

   logic [LEVEL_BITS-1:0]  level;
   logic [LEVEL_BITS-1:0]  net;
   logic                   at_or_above;
   logic [SUM_BITS-1:0]    rounded;
   logic [WEIGHT_BITS-1:0] scaled;

   // pipeline moves unless the last stage waits on a full queue
   assign stall        = s3_valid_ff & push_full;
   assign advance      = ~stall;
   assign req_ch.ready = advance;
   assign csr_ch.ready = 1'b1;

   // stage 1: capture word
   assign s1_valid_in  = advance ? (req_ch.valid & req_ch.ready) : s1_valid_ff;
   assign s1_weigh_in  = advance ? req_ch.req_type : s1_weigh_ff;
   assign s1_sample_in = advance ? req_ch.sample : s1_sample_ff;

   // stage 2: reciprocal multiply for the divide by 100
   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;
   assign s2_weigh_in = advance ? s1_weigh_ff : s2_weigh_ff;
   assign s2_prod_in  = advance ? PROD_BITS'(s1_sample_ff) * PROD_BITS'(DIV100_MUL)
                                : s2_prod_ff;

   // stage 3: tare compare, net value and gain multiply
   assign level       = s2_prod_ff[DIV100_SHIFT +: LEVEL_BITS];
   assign at_or_above = (level >= tare_ff);
   assign net         = level - tare_ff;
   assign s3_valid_in = advance ? (s2_valid_ff & s2_weigh_ff) : s3_valid_ff;
   assign s3_upd_in   = advance ? at_or_above : s3_upd_ff;
   assign s3_prod_in  = advance ? NET_BITS'(net) * NET_BITS'(gain_ff) : s3_prod_ff;
   assign tare_in     = (advance && s2_valid_ff && !s2_weigh_ff) ? level : tare_ff;

   // rounding, shift and saturation at the queue input
   assign rounded    = SUM_BITS'(s3_prod_ff) + SUM_BITS'(ROUND_Q16);
   assign scaled     = (|rounded[SUM_BITS-1:32]) ? {WEIGHT_BITS{1'b1}} : rounded[31:16];
   assign push_valid = s3_valid_ff;
   assign push_data  = s3_upd_ff ? scaled : net_weight_ff;
   assign net_weight_in = (s3_valid_ff && !push_full && s3_upd_ff) ? scaled
                                                                     : net_weight_ff;

   // gain register
   assign gain_in = csr_ch.valid ? csr_ch.gain_q16 : gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         tare_ff       <= '0;
         net_weight_ff <= '0;
         gain_ff       <= GAIN_RESET;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         s3_valid_ff   <= s3_valid_in;
         tare_ff       <= tare_in;
         net_weight_ff <= net_weight_in;
         gain_ff       <= gain_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_weigh_ff  <= s1_weigh_in;
      s1_sample_ff <= s1_sample_in;
      s2_weigh_ff  <= s2_weigh_in;
      s2_prod_ff   <= s2_prod_in;
      s3_upd_ff    <= s3_upd_in;
      s3_prod_ff   <= s3_prod_in;
   end

   `ASSERT_NEXT(a_front_stall_keeps_word, clock, reset, stall, s3_valid_ff)

endmodule

// ===== rtl/lctwd_back.sv =====
// -----------------------------------------------------------------------------
// lctwd_back
// Byte sequencer: turns one queued weight into a display update.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module lctwd_back
   import lctwd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  logic [WEIGHT_BITS-1:0] q_data,
   output logic                   q_pop,
   lctwd_rsp_if.source            rsp_ch
);

   seq_state_type state_ff, state_in;
   logic [3:0]             pos_ff, pos_in;
   logic [2:0]             dig_ff, dig_in;
   logic [WEIGHT_BITS-1:0] bin_ff, bin_in;
   logic [BCD_BITS-1:0]    bcd_ff, bcd_in;
   logic [3:0]             conv_cnt_ff, conv_cnt_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_cmd_ff, rsp_cmd_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       can_emit;
   logic       has_byte;
   logic       emit;
   logic [7:0] next_byte;
   logic       next_cmd;
   logic       next_last;
   logic [3:0] cur_digit;
   logic [BCD_BITS+WEIGHT_BITS-1:0] dd_one;
   logic [BCD_BITS+WEIGHT_BITS-1:0] dd_two;

   // one double-dabble step: adjust digits of five or more, then shift
   function automatic logic [BCD_BITS+WEIGHT_BITS-1:0] dd_step(
      input logic [BCD_BITS+WEIGHT_BITS-1:0] v
   );
      logic [BCD_BITS+WEIGHT_BITS-1:0] t;
      t = v;
      for (int k = 0; k < BCD_BITS / 4; k++) begin
         if (t[WEIGHT_BITS + 4*k +: 4] >= 4'd5) begin
            t[WEIGHT_BITS + 4*k +: 4] = t[WEIGHT_BITS + 4*k +: 4] + 4'd3;
         end
      end
      return {t[BCD_BITS+WEIGHT_BITS-2:0], 1'b0};
   endfunction

   // position of the first digit shown, leading zeros blanked
   function automatic logic [2:0] lead_digit(input logic [WEIGHT_BITS-1:0] w);
      if (w >= 16'd10000) begin
         return 3'd0;
      end else if (w >= 16'd1000) begin
         return 3'd1;
      end else if (w >= 16'd100) begin
         return 3'd2;
      end else if (w >= 16'd10) begin
         return 3'd3;
      end else begin
         return DIGIT_LAST;
      end
   endfunction

   assign can_emit = ~rsp_valid_ff | rsp_ch.ready;
   assign emit     = has_byte & can_emit;
   assign q_pop    = emit & (state_ff == SEQ_IDLE);

   // digit select, ten-thousands first
   always_comb begin
      case (dig_ff)
         3'd0:    cur_digit = bcd_ff[19:16];
         3'd1:    cur_digit = bcd_ff[15:12];
         3'd2:    cur_digit = bcd_ff[11:8];
         3'd3:    cur_digit = bcd_ff[7:4];
         default: cur_digit = bcd_ff[3:0];
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE:  if (emit) state_in = SEQ_HEAD;
         SEQ_HEAD:  if (emit && pos_ff == HEAD_LAST) state_in = SEQ_DIGIT;
         SEQ_DIGIT: if (emit && dig_ff == DIGIT_LAST) state_in = SEQ_SPACE;
         SEQ_SPACE: if (emit) state_in = SEQ_UNIT;
         SEQ_UNIT:  if (emit) state_in = SEQ_IDLE;
         default:   state_in = SEQ_IDLE;
      endcase
   end

   // byte for the current position
   always_comb begin
      has_byte  = 1'b1;
      next_byte = CHAR_SPACE;
      next_cmd  = 1'b0;
      next_last = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: begin
            has_byte  = ~q_empty;
            next_byte = CURSOR_LINE2;
            next_cmd  = 1'b1;
         end
         SEQ_HEAD: begin
            if (pos_ff == HEAD_LAST) begin
               next_byte = CURSOR_LINE2;
               next_cmd  = 1'b1;
            end
         end
         SEQ_DIGIT: begin
            next_byte = CHAR_ZERO | {4'b0000, cur_digit};
         end
         SEQ_SPACE: begin
            next_byte = CHAR_SPACE;
         end
         SEQ_UNIT: begin
            next_byte = CHAR_UNIT;
            next_last = 1'b1;
         end
         default: begin
            has_byte = 1'b0;
         end
      endcase
   end

   // position counters
   assign pos_in = (state_ff == SEQ_IDLE && emit) ? 4'd1
                 : (state_ff == SEQ_HEAD && emit) ? pos_ff + 4'd1 : pos_ff;
   assign dig_in = q_pop ? lead_digit(q_data)
                 : (state_ff == SEQ_DIGIT && emit) ? dig_ff + 3'd1 : dig_ff;

   // binary to decimal, two bits a cycle while the header goes out
   assign dd_one = dd_step({bcd_ff, bin_ff});
   assign dd_two = dd_step(dd_one);
   always_comb begin
      bin_in      = bin_ff;
      bcd_in      = bcd_ff;
      conv_cnt_in = conv_cnt_ff;
      if (q_pop) begin
         bin_in      = q_data;
         bcd_in      = '0;
         conv_cnt_in = CONV_CYCLES;
      end else if (conv_cnt_ff != 4'd0) begin
         bin_in      = dd_two[WEIGHT_BITS-1:0];
         bcd_in      = dd_two[BCD_BITS+WEIGHT_BITS-1:WEIGHT_BITS];
         conv_cnt_in = conv_cnt_ff - 4'd1;
      end
   end

   // output register
   assign rsp_valid_in = emit ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   assign rsp_byte_in  = emit ? next_byte : rsp_byte_ff;
   assign rsp_cmd_in   = emit ? next_cmd : rsp_cmd_ff;
   assign rsp_last_in  = emit ? next_last : rsp_last_ff;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.lcd_byte   = rsp_byte_ff;
   assign rsp_ch.is_command = rsp_cmd_ff;
   assign rsp_ch.last       = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         pos_ff       <= '0;
         conv_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         conv_cnt_ff  <= conv_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dig_ff      <= dig_in;
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_cmd_ff  <= rsp_cmd_in;
      rsp_last_ff <= rsp_last_in;
   end

   `ASSERT_IMPLIES(a_back_digits_ready, clock, reset, state_ff == SEQ_DIGIT, conv_cnt_ff == 4'd0)
   `ASSERT_NEXT(a_back_unit_ends, clock, reset, emit && state_ff == SEQ_UNIT, state_ff == SEQ_IDLE)

endmodule

// ===== rtl/load_cell_tare_weigh_display.sv =====
// -----------------------------------------------------------------------------
// load_cell_tare_weigh_display
// Load-cell tare and weigh block with a character display byte stream.
// -----------------------------------------------------------------------------
// A tare request stores sample/100 as the empty-pan level and sends nothing;
// a weigh request computes ((sample/100 - tare) * gain_q16 + 3277) >> 16,
// saturated at 65535, or keeps the last weight when the sample is below tare,
// and then sends one display update: 0xC0, seven spaces, 0xC0, 1 to 5 digits,
// a space and 'g' (12 to 16 bytes, last set on 'g'). The byte sequencer sends
// one byte per cycle while output is ready; tare requests go one per cycle
// unless a full queue stalls them. Requests pass a three-stage front pipeline
// (divide, tare and gain multiply) into a four-entry weight queue, so input
// is taken during a display update until the queue is full. gain_q16 must
// be written only while the block is idle (not enforced); it resets to 16591.
// -----------------------------------------------------------------------------
module load_cell_tare_weigh_display
   import lctwd_pkg::*;
#(
   parameter int SAMPLE_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   lctwd_req_if.sink   req_ch,
   lctwd_rsp_if.source rsp_ch,
   lctwd_csr_if.sink   csr_ch
);

   logic                   push_valid;
   logic [WEIGHT_BITS-1:0] push_data;
   logic                   q_full;
   logic                   q_pop;
   logic [WEIGHT_BITS-1:0] q_data;
   logic                   q_empty;

   // request front end
   lctwd_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_full  (q_full)
   );

   // weight queue
   lctwd_fifo #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (q_pop),
      .pop_data   (q_data),
      .empty      (q_empty)
   );

   // display byte sequencer
   lctwd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule
